FILE: design/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared widths, fixed-point scales, sector codes and request types for the
// rgb to hsv converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhsv_pkg;

    localparam int COMPONENT_BITS = 8;
    localparam int HUE_FRAC_BITS  = 4;
    localparam int SAT_FRAC_BITS  = 12;

    localparam int RED_W   = 8;
    localparam int GREEN_W = 8;
    localparam int BLUE_W  = 8;
    localparam int HUE_W   = 13;
    localparam int SAT_W   = 13;
    localparam int VAL_W   = 8;

    localparam int HUE_SCALE = 60 * (1 << HUE_FRAC_BITS);
    localparam int HUE_FULL  = 360 * (1 << HUE_FRAC_BITS);

    // quotient widths: hue below 5 sectors worth, saturation up to one
    localparam int HUE_Q_W   = $clog2(5 * HUE_SCALE + 1);
    localparam int SAT_Q_W   = $clog2((1 << SAT_FRAC_BITS) + 1);
    localparam int DIV_STEPS = (HUE_Q_W > SAT_Q_W) ? HUE_Q_W : SAT_Q_W;

    localparam int NUM_W = COMPONENT_BITS + DIV_STEPS;
    localparam int SUM_W = COMPONENT_BITS + 4;
    localparam int ABS_W = COMPONENT_BITS + 3;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        logic [RED_W-1:0]   red;
        logic [GREEN_W-1:0] green;
        logic [BLUE_W-1:0]  blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [VAL_W-1:0] brightness;
    } hsv_t;

endpackage

`default_nettype wire

FILE: design/rgb_to_hsv_convert.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert
// Pipelined rgb to hsv conversion with two restoring dividers, one quotient
// bit per stage, running side by side for hue and saturation.
// ----------------------------------------------------------------------------
// a result passes from the accepting edge through stage a, stage b, the divider registers and the output reg
// throughput: one request per cycle while the output is not stalled, set by the one-bit-per-stage dividers
// a stalled output holds only the stages behind it that are full
// empty stages collapse, so input is taken whenever any stage ahead is free
// reset clears all valid bits; payload registers are not reset
`default_nettype none

module rgb_to_hsv_convert
    import rhsv_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire pixel_t pixel,
    input  wire logic   pixel_valid,
    output logic        pixel_stall,
    output hsv_t        hsv,
    output logic        hsv_valid,
    input  wire logic   hsv_stall
);

    localparam int CD = COMPONENT_BITS;

    // handshake chain
    logic                 a_ready;
    logic                 b_ready;
    logic [DIV_STEPS:0]   dv_ready;
    logic                 out_ready;

    // stage a: max, min, sector, difference
    logic                 a_valid_reg, a_valid_next;
    logic [CD-1:0]        a_max_reg, a_max_next;
    logic [CD-1:0]        a_spread_reg, a_spread_next;
    logic signed [CD:0]   a_diff_reg, a_diff_next;
    sector_t              a_sector_reg, a_sector_next;
    logic [CD-1:0]        in_r, in_g, in_b, in_min;

    // stage b: offset sum and magnitude
    logic                 b_valid_reg, b_valid_next;
    logic [CD-1:0]        b_max_reg;
    logic [CD-1:0]        b_spread_reg;
    logic [ABS_W-1:0]     b_abs_reg, b_abs_next;
    logic                 b_neg_reg, b_neg_next;
    logic signed [SUM_W-1:0] b_sum;
    logic [SUM_W-1:0]     k_term;

    // divider stages
    logic [NUM_W-1:0]     hue_num, sat_num;
    logic                 dv_valid_reg [0:DIV_STEPS];
    logic                 dv_valid_next [0:DIV_STEPS];
    logic [CD-1:0]        dv_hue_rem_reg [0:DIV_STEPS];
    logic [CD-1:0]        dv_hue_rem_next [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_hue_low_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_hue_low_next [0:DIV_STEPS];
    logic [CD-1:0]        dv_sat_rem_reg [0:DIV_STEPS];
    logic [CD-1:0]        dv_sat_rem_next [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_sat_low_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_sat_low_next [0:DIV_STEPS];
    logic [CD-1:0]        dv_spread_reg [0:DIV_STEPS];
    logic [CD-1:0]        dv_spread_next [0:DIV_STEPS];
    logic [CD-1:0]        dv_max_reg [0:DIV_STEPS];
    logic [CD-1:0]        dv_max_next [0:DIV_STEPS];
    logic                 dv_neg_reg [0:DIV_STEPS];
    logic                 dv_neg_next [0:DIV_STEPS];

    // output register
    logic                 hsv_valid_reg, hsv_valid_next;
    hsv_t                 hsv_reg, hsv_next;
    logic [HUE_W-1:0]     q_hue;

    always_comb
    begin
        out_ready = !hsv_valid_reg || !hsv_stall;
        dv_ready[DIV_STEPS] = !dv_valid_reg[DIV_STEPS] || out_ready;
        for (int i = DIV_STEPS - 1; i >= 0; i--)
        begin
            dv_ready[i] = !dv_valid_reg[i] || dv_ready[i+1];
        end
        b_ready = !b_valid_reg || dv_ready[0];
        a_ready = !a_valid_reg || b_ready;
    end

    assign pixel_stall = !a_ready;
    assign hsv_valid   = hsv_valid_reg;
    assign hsv         = hsv_reg;

    // stage a
    always_comb
    begin
        in_r = pixel.red[CD-1:0];
        in_g = pixel.green[CD-1:0];
        in_b = pixel.blue[CD-1:0];

        priority if (in_r >= in_g && in_r >= in_b)
        begin
            a_sector_next = SEC_RED;
            a_max_next    = in_r;
        end
        else if (in_g >= in_b)
        begin
            a_sector_next = SEC_GREEN;
            a_max_next    = in_g;
        end
        else
        begin
            a_sector_next = SEC_BLUE;
            a_max_next    = in_b;
        end

        in_min = in_r;
        if (in_g < in_min)
        begin
            in_min = in_g;
        end
        if (in_b < in_min)
        begin
            in_min = in_b;
        end
        a_spread_next = a_max_next - in_min;

        unique case (a_sector_next)
            SEC_RED:   a_diff_next = $signed({1'b0, in_g}) - $signed({1'b0, in_b});
            SEC_GREEN: a_diff_next = $signed({1'b0, in_b}) - $signed({1'b0, in_r});
            SEC_BLUE:  a_diff_next = $signed({1'b0, in_r}) - $signed({1'b0, in_g});
            default:   a_diff_next = '0;
        endcase

        a_valid_next = a_ready ? pixel_valid : a_valid_reg;
    end

    // stage b
    always_comb
    begin
        unique case (a_sector_reg)
            SEC_RED:   k_term = '0;
            SEC_GREEN: k_term = SUM_W'({a_spread_reg, 1'b0});
            SEC_BLUE:  k_term = SUM_W'({a_spread_reg, 2'b00});
            default:   k_term = '0;
        endcase
        b_sum        = SUM_W'(a_diff_reg) + $signed(k_term);
        b_neg_next   = b_sum[SUM_W-1];
        b_abs_next   = b_neg_next ? ABS_W'(-b_sum) : ABS_W'(b_sum);
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    end

    // divider entry and steps
    always_comb
    begin
        logic [CD:0] t_h;
        logic [CD:0] t_s;
        logic        ge_h;
        logic        ge_s;

        hue_num = NUM_W'(b_abs_reg) * NUM_W'(HUE_SCALE);
        sat_num = NUM_W'(b_spread_reg) << SAT_FRAC_BITS;

        dv_valid_next[0]   = dv_ready[0] ? b_valid_reg : dv_valid_reg[0];
        dv_hue_rem_next[0] = hue_num[NUM_W-1 -: CD];
        dv_hue_low_next[0] = hue_num[DIV_STEPS-1:0];
        dv_sat_rem_next[0] = sat_num[NUM_W-1 -: CD];
        dv_sat_low_next[0] = sat_num[DIV_STEPS-1:0];
        dv_spread_next[0]  = b_spread_reg;
        dv_max_next[0]     = b_max_reg;
        dv_neg_next[0]     = b_neg_reg;

        for (int i = 1; i <= DIV_STEPS; i++)
        begin
            t_h  = {dv_hue_rem_reg[i-1], dv_hue_low_reg[i-1][DIV_STEPS-1]};
            t_s  = {dv_sat_rem_reg[i-1], dv_sat_low_reg[i-1][DIV_STEPS-1]};
            ge_h = t_h >= {1'b0, dv_spread_reg[i-1]};
            ge_s = t_s >= {1'b0, dv_max_reg[i-1]};

            dv_valid_next[i]   = dv_ready[i] ? dv_valid_reg[i-1] : dv_valid_reg[i];
            dv_hue_rem_next[i] = ge_h ? CD'(t_h - {1'b0, dv_spread_reg[i-1]}) : t_h[CD-1:0];
            dv_sat_rem_next[i] = ge_s ? CD'(t_s - {1'b0, dv_max_reg[i-1]}) : t_s[CD-1:0];
            dv_hue_low_next[i] = {dv_hue_low_reg[i-1][DIV_STEPS-2:0], ge_h};
            dv_sat_low_next[i] = {dv_sat_low_reg[i-1][DIV_STEPS-2:0], ge_s};
            dv_spread_next[i]  = dv_spread_reg[i-1];
            dv_max_next[i]     = dv_max_reg[i-1];
            dv_neg_next[i]     = dv_neg_reg[i-1];
        end
    end

    // sign fix, wrap and grey override
    always_comb
    begin
        q_hue = HUE_W'(dv_hue_low_reg[DIV_STEPS]);
        if (dv_spread_reg[DIV_STEPS] == '0)
        begin
            hsv_next.hue        = '0;
            hsv_next.saturation = '0;
        end
        else
        begin
            if (dv_neg_reg[DIV_STEPS] && q_hue != '0)
            begin
                hsv_next.hue = HUE_W'(HUE_FULL) - q_hue;
            end
            else if (dv_neg_reg[DIV_STEPS])
            begin
                hsv_next.hue = '0;
            end
            else
            begin
                hsv_next.hue = q_hue;
            end
            hsv_next.saturation = SAT_W'(dv_sat_low_reg[DIV_STEPS]);
        end
        hsv_next.brightness = VAL_W'(dv_max_reg[DIV_STEPS]);
        hsv_valid_next      = out_ready ? dv_valid_reg[DIV_STEPS] : hsv_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            hsv_valid_reg <= 1'b0;
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            hsv_valid_reg <= hsv_valid_next;
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                dv_valid_reg[i] <= dv_valid_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_max_reg    <= a_max_next;
            a_spread_reg <= a_spread_next;
            a_diff_reg   <= a_diff_next;
            a_sector_reg <= a_sector_next;
        end
        if (b_ready)
        begin
            b_max_reg    <= a_max_reg;
            b_spread_reg <= a_spread_reg;
            b_abs_reg    <= b_abs_next;
            b_neg_reg    <= b_neg_next;
        end
        for (int i = 0; i <= DIV_STEPS; i++)
        begin
            if (dv_ready[i])
            begin
                dv_hue_rem_reg[i] <= dv_hue_rem_next[i];
                dv_hue_low_reg[i] <= dv_hue_low_next[i];
                dv_sat_rem_reg[i] <= dv_sat_rem_next[i];
                dv_sat_low_reg[i] <= dv_sat_low_next[i];
                dv_spread_reg[i]  <= dv_spread_next[i];
                dv_max_reg[i]     <= dv_max_next[i];
                dv_neg_reg[i]     <= dv_neg_next[i];
            end
        end
        if (out_ready)
        begin
            hsv_reg <= hsv_next;
        end
    end

    // checks
    hue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid_reg |-> (hsv_reg.hue < HUE_W'(HUE_FULL)))
        else $error("hue outside one turn");

    sat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid_reg |-> (hsv_reg.saturation <= SAT_W'(1 << SAT_FRAC_BITS)))
        else $error("saturation above one");

    grey_has_no_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid_reg && hsv_reg.saturation == '0) |-> (hsv_reg.hue == '0))
        else $error("hue set on a grey pixel");

    hue_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[DIV_STEPS] && dv_spread_reg[DIV_STEPS] != '0)
            |-> (dv_hue_rem_reg[DIV_STEPS] < dv_spread_reg[DIV_STEPS]))
        else $error("hue remainder not below divisor");

    sat_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[DIV_STEPS] && dv_max_reg[DIV_STEPS] != '0)
            |-> (dv_sat_rem_reg[DIV_STEPS] < dv_max_reg[DIV_STEPS]))
        else $error("saturation remainder not below divisor");

    empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !hsv_valid_reg |-> !pixel_stall)
        else $error("input stalled with an empty output");

endmodule

`default_nettype wire

FILE: tb/rgb_to_hsv_convert_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_tb
// Sends corner, tie and random pixels through the converter, with both sides
// idling at random in all but the last random run. Each result is checked field
// by field against a fixed-point hsv computation that the bench does on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rgb_to_hsv_convert_tb
    import rhsv_pkg::*;
;

    logic   clk;
    logic   rst_n;
    pixel_t pixel;
    logic   pixel_valid;
    logic   pixel_stall;
    hsv_t   hsv;
    logic   hsv_valid;
    logic   hsv_stall;

    int     send_idle_pct;
    int     recv_stall_pct;
    int     mismatches;
    hsv_t   expected_hsv[$];

    rgb_to_hsv_convert dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .hsv        (hsv),
        .hsv_valid  (hsv_valid),
        .hsv_stall  (hsv_stall)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic hsv_t hsv_of(pixel_t p);
        int      r;
        int      g;
        int      b;
        int      hi;
        int      lo;
        int      spread;
        int      diff;
        int      k;
        int      h;
        sector_t sec;
        hsv_t    res;
        r = p.red;
        g = p.green;
        b = p.blue;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        spread = hi - lo;
        res.hue = '0;
        res.saturation = '0;
        res.brightness = VAL_W'(hi);
        if (spread > 0)
        begin
            if (hi == r)
                sec = SEC_RED;
            else if (hi == g)
                sec = SEC_GREEN;
            else
                sec = SEC_BLUE;
            case (sec)
                SEC_RED:
                begin
                    diff = g - b;
                    k = 0;
                end
                SEC_GREEN:
                begin
                    diff = b - r;
                    k = 2;
                end
                default:
                begin
                    diff = r - g;
                    k = 4;
                end
            endcase
            // integer division truncates toward zero before the wrap
            h = ((diff + k * spread) * HUE_SCALE) / spread;
            if (h < 0) h += HUE_FULL;
            res.hue = HUE_W'(h);
            res.saturation = SAT_W'((spread << SAT_FRAC_BITS) / hi);
        end
        return res;
    endfunction

    function automatic logic [7:0] edge_component();
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            3: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        logic [7:0] base;
        p = pixel_t'(24'($urandom));
        base = 8'($urandom);
        case ($urandom_range(9))
            6:
                p = '{base, base, base};
            7:
            begin
                case ($urandom_range(2))
                    0: p.green = p.red;
                    1: p.blue = p.green;
                    default: p.blue = p.red;
                endcase
            end
            8:
                p = '{edge_component(), edge_component(), edge_component()};
            9:
            begin
                p.red = base + 8'($urandom_range(2));
                p.green = base + 8'($urandom_range(2));
                p.blue = base + 8'($urandom_range(2));
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pixel(input pixel_t p);
        logic stalled;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel <= p;
        pixel_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            stalled = pixel_stall;
            if (!stalled) expected_hsv.insert(expected_hsv.size(), hsv_of(p));
            @(posedge clk);
        end
        while (stalled);
    endtask

    // receiver stall
    always @(posedge clk)
    begin
        hsv_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // result check, sampled on the falling edge before the accepting edge
    always @(negedge clk)
    begin
        hsv_t want;
        if (rst_n && hsv_valid && !hsv_stall)
        begin
            if (expected_hsv.size() == 0)
            begin
                $error("unexpected result: hue %0d saturation %0d brightness %0d",
                       hsv.hue, hsv.saturation, hsv.brightness);
                mismatches++;
            end
            else
            begin
                want = expected_hsv.pop_front();
                if (hsv.hue !== want.hue)
                begin
                    $error("hue: expected %0d, actual %0d", want.hue, hsv.hue);
                    mismatches++;
                end
                if (hsv.saturation !== want.saturation)
                begin
                    $error("saturation: expected %0d, actual %0d",
                           want.saturation, hsv.saturation);
                    mismatches++;
                end
                if (hsv.brightness !== want.brightness)
                begin
                    $error("brightness: expected %0d, actual %0d",
                           want.brightness, hsv.brightness);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_corner_pixels();
        send_pixel('{8'd0, 8'd0, 8'd0});
        send_pixel('{8'd255, 8'd255, 8'd255});
        send_pixel('{8'd128, 8'd128, 8'd128});
        send_pixel('{8'd255, 8'd0, 8'd0});
        send_pixel('{8'd0, 8'd255, 8'd0});
        send_pixel('{8'd0, 8'd0, 8'd255});
        send_pixel('{8'd255, 8'd255, 8'd0});
        send_pixel('{8'd0, 8'd255, 8'd255});
        send_pixel('{8'd255, 8'd0, 8'd255});
        send_pixel('{8'd1, 8'd0, 8'd0});
        send_pixel('{8'd0, 8'd0, 8'd1});
        send_pixel('{8'd170, 8'd85, 8'd0});
        send_pixel('{8'd0, 8'd255, 8'd254});
    endtask

    task automatic test_ties_and_wrap();
        // red beats green, green beats blue, red beats blue
        send_pixel('{8'd200, 8'd200, 8'd50});
        send_pixel('{8'd50, 8'd200, 8'd200});
        send_pixel('{8'd200, 8'd50, 8'd200});
        send_pixel('{8'd255, 8'd255, 8'd254});
        // red sector with negative difference wraps back below 360
        send_pixel('{8'd255, 8'd0, 8'd1});
        send_pixel('{8'd255, 8'd254, 8'd255});
        send_pixel('{8'd2, 8'd0, 8'd1});
        send_pixel('{8'd255, 8'd100, 8'd101});
    endtask

    task automatic test_random_pixels(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    initial
    begin
        rst_n = 1'b0;
        pixel = '0;
        pixel_valid = 1'b0;
        mismatches = 0;
        send_idle_pct = 27;
        recv_stall_pct = 84;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_pixels();
        test_ties_and_wrap();
        test_random_pixels(460);

        send_idle_pct = 84;
        recv_stall_pct = 27;
        test_random_pixels(460);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_pixels(460);

        pixel_valid <= 1'b0;
        while (expected_hsv.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("** rgb_to_hsv_convert: PASSED **");
        else
            $display("** rgb_to_hsv_convert: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** rgb_to_hsv_convert: FAILED **");
        $finish;
    end

endmodule
